[design/lenorm_pkg.sv]
// Shared constants, result entry types and ending expansion for the line ending normaliser.
package lenorm_pkg;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam logic [1:0] ENDING_LF   = 2'd0;
   localparam logic [1:0] ENDING_CRLF = 2'd1;
   localparam logic [1:0] ENDING_CR   = 2'd2;

   localparam logic CSR_TARGET_ENDING = 1'b0;
   localparam logic CSR_ADD_FINAL_EOL = 1'b1;

   localparam int LIST_DEPTH = 4;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_present;
      logic       out_last;
   } rsp_entry_type;

   typedef rsp_entry_type [LIST_DEPTH-1:0] rsp_list_type;

   typedef struct packed {
      rsp_list_type list;
      logic [1:0]   count;
   } rsp_item_type;

   // Append the configured line ending to a result list.
   function automatic rsp_item_type put_ending(rsp_item_type item, logic [1:0] target);
      rsp_item_type res;
      res = item;
      unique case (target)
         ENDING_CRLF: begin
            res.list[res.count]         = '{out_byte: CHAR_CR, out_present: 1'b1, out_last: 1'b0};
            res.list[res.count + 2'd1]  = '{out_byte: CHAR_LF, out_present: 1'b1, out_last: 1'b0};
            res.count                   = res.count + 2'd2;
         end
         ENDING_CR: begin
            res.list[res.count] = '{out_byte: CHAR_CR, out_present: 1'b1, out_last: 1'b0};
            res.count           = res.count + 2'd1;
         end
         default: begin
            res.list[res.count] = '{out_byte: CHAR_LF, out_present: 1'b1, out_last: 1'b0};
            res.count           = res.count + 2'd1;
         end
      endcase
      return res;
   endfunction

endpackage

[design/lenorm_decode.sv]
// Per-byte decode: line state registers and the list of results one input item causes.
module lenorm_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic                  byte_present,
   input  logic                  end_of_text,
   input  logic [1:0]            target_ending,
   input  logic                  add_final_eol,
   output lenorm_pkg::rsp_item_type item
);
   import lenorm_pkg::*;

   logic drop_next_lf_ff, drop_next_lf_in;
   logic wrote_anything_ff, wrote_anything_in;
   logic last_was_ending_ff, last_was_ending_in;

   always_comb begin
      rsp_item_type work;
      logic         drop_v, wrote_v, last_v;
      work   = '0;
      drop_v = drop_next_lf_ff;
      wrote_v = wrote_anything_ff;
      last_v = last_was_ending_ff;

      if (byte_present) begin
         if (drop_next_lf_ff && data_byte == CHAR_LF) begin
            drop_v = 1'b0;
         end else if (data_byte == CHAR_CR || data_byte == CHAR_LF) begin
            work    = put_ending(work, target_ending);
            drop_v  = (data_byte == CHAR_CR);
            wrote_v = 1'b1;
            last_v  = 1'b1;
         end else begin
            work.list[work.count] = '{out_byte: data_byte, out_present: 1'b1, out_last: 1'b0};
            work.count            = work.count + 2'd1;
            drop_v  = 1'b0;
            wrote_v = 1'b1;
            last_v  = 1'b0;
         end
      end

      if (end_of_text) begin
         if (add_final_eol && (!wrote_v || !last_v)) begin
            work = put_ending(work, target_ending);
         end
         // bare end mark when the text closes with nothing to send
         if (work.count == 2'd0) begin
            work.count = 2'd1;
         end
         work.list[work.count - 2'd1].out_last = 1'b1;
         drop_v  = 1'b0;
         wrote_v = 1'b0;
         last_v  = 1'b0;
      end

      item               = work;
      drop_next_lf_in    = drop_v;
      wrote_anything_in  = wrote_v;
      last_was_ending_in = last_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drop_next_lf_ff    <= 1'b0;
         wrote_anything_ff  <= 1'b0;
         last_was_ending_ff <= 1'b0;
      end else if (accept) begin
         drop_next_lf_ff    <= drop_next_lf_in;
         wrote_anything_ff  <= wrote_anything_in;
         last_was_ending_ff <= last_was_ending_in;
      end
   end

endmodule

[design/lenorm_emit.sv]
// Result list register and output register; sends the list one entry per transfer.
module lenorm_emit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  lenorm_pkg::rsp_item_type   item,
   output logic                       can_load,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);
   import lenorm_pkg::*;

   rsp_list_type  list_ff, list_in;
   logic [1:0]    count_ff, count_in;
   logic [1:0]    index_ff, index_in;
   logic          valid_ff, valid_in;
   rsp_entry_type out_ff, out_in;
   logic          empty, last_one, out_free, advance;

   assign empty    = (index_ff == count_ff);
   assign last_one = (({1'b0, index_ff} + 3'd1) == {1'b0, count_ff});
   assign out_free = !valid_ff || rsp_tready;
   assign advance  = !empty && out_free;
   assign can_load = empty || (last_one && out_free);

   always_comb begin
      list_in  = list_ff;
      count_in = count_ff;
      index_in = index_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      if (advance) begin
         out_in   = list_ff[index_ff];
         valid_in = 1'b1;
         index_in = index_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         list_in  = item.list;
         count_in = item.count;
         index_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         index_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         index_ff <= index_in;
         valid_ff <= valid_in;
      end
      list_ff <= list_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = out_ff.out_byte;
   assign rsp_tuser  = out_ff.out_present;
   assign rsp_tlast  = out_ff.out_last;

endmodule

[design/line_ending_normaliser.sv]
// Top level of the line ending normaliser: configuration registers, decode and result output.
// A byte's results pass through the result list register and then the output register.
// Throughput: one input byte per cycle while each byte yields at most one result and
//   rsp_tready stays high; an item that expands to two or three results holds req_tready
//   low until its last result moves to the output register; a stalled output does too.
// Reset: synchronous, active high; clears line state, result list, output valid and both
//   configuration registers (LF ending, no appended final ending).
module line_ending_normaliser (
   input  logic       clock,
   input  logic       reset,
   // input bytes
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] byte_present
   input  logic       req_tlast,   // end_of_text
   // normalised bytes
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] out_present
   output logic       rsp_tlast,   // out_last
   // configuration writes
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [1:0] csr_wdata
);
   import lenorm_pkg::*;

   logic [1:0]   target_ending_ff;
   logic         add_final_eol_ff;
   logic         accept;
   logic         can_load;
   rsp_item_type item;

   // Hold the configuration; each register keeps its last written value.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ending_ff <= ENDING_LF;
         add_final_eol_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_ENDING: target_ending_ff <= csr_wdata;
            CSR_ADD_FINAL_EOL: add_final_eol_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Take a new byte whenever the result list will be empty after this cycle.
   assign req_tready = can_load;
   assign accept     = req_tvalid && req_tready;

   // Decode the byte against the line state into a list of up to three results.
   lenorm_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_tdata),
      .byte_present  (req_tuser),
      .end_of_text   (req_tlast),
      .target_ending (target_ending_ff),
      .add_final_eol (add_final_eol_ff),
      .item          (item)
   );

   // Register the list and advance it one transfer at a time to the output.
   lenorm_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .item       (item),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[design/lenorm_checker.sv]
// Port-level checks for the line ending normaliser, bound to the top level.
module lenorm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tuser,
   input logic       rsp_tlast
);

   a_reset_clears_valid: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   a_bare_mark_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("bare end mark without last");

   a_bare_mark_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 8'h00)
      else $error("bare end mark carries data");

endmodule

bind line_ending_normaliser lenorm_checker u_lenorm_checker (.*);
